// ===== hdl/tuple_field_decoder_projected_assert.svh =====
// Assertion macros used by the row record field decoder result queue.
`ifndef TUPLE_FIELD_DECODER_PROJECTED_ASSERT_SVH
`define TUPLE_FIELD_DECODER_PROJECTED_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfd assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define TFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfd assertion failed");

`endif

// ===== hdl/tfd_pkg.sv =====
// Types and codes shared by the row record field decoder.
`timescale 1ns / 1ps

package tfd_pkg;

    typedef enum logic [2:0] {
        PH_COUNT_LO = 3'd0,
        PH_COUNT_HI = 3'd1,
        PH_TAG      = 3'd2,
        PH_SCALAR   = 3'd3,
        PH_LENGTH   = 3'd4,
        PH_PAYLOAD  = 3'd5,
        PH_TRAIL    = 3'd6,
        PH_DROP     = 3'd7
    } phase_t;

    localparam logic [1:0] KIND_SCALAR = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_BYTE   = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    localparam logic [2:0] TYPE_NULL    = 3'd0;
    localparam logic [2:0] TYPE_INTEGER = 3'd1;
    localparam logic [2:0] TYPE_REAL    = 3'd2;
    localparam logic [2:0] TYPE_TEXT    = 3'd3;
    localparam logic [2:0] TYPE_BOOLEAN = 3'd4;
    localparam logic [2:0] TYPE_BLOB    = 3'd5;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_BAD_PROJ  = 3'd1;
    localparam logic [2:0] ERR_NO_TAG    = 3'd2;
    localparam logic [2:0] ERR_BAD_TAG   = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;

    localparam logic [1:0] CFG_COLUMN_MASK = 2'd0;
    localparam logic [1:0] CFG_PROJECT_ALL = 2'd1;

    // Result queue: four entries, so a two-result step always fits.
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       record_end;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] column;
        logic [2:0]  type_code;
        logic [63:0] data;
        logic [2:0]  error;
        logic        last;
    } result_item_t;

    // Results of one decoded byte: count and up to two items in order.
    typedef struct packed {
        logic [1:0]   count;
        result_item_t first;
        result_item_t second;
    } push_t;

endpackage

// ===== hdl/tuple_field_decoder_projected.sv =====
// Top level of the row record field decoder with column projection.
`timescale 1ns / 1ps

// Channel   Handshake                    Payload                      Direction
// byte      byte_valid / byte_stall      byte_item (byte_item_t)      into block
// result    result_valid / result_stall  result_item (result_item_t)  out of block
// cfg       cfg_valid / cfg_ready        cfg_index, cfg_data          into block
//
// One record byte is taken every cycle while the result queue has two free entries.
// Each byte is decoded in its accept cycle; its results are offered from the next cycle.
// A byte yields zero, one or two results; only a last byte that also carries a field
// result yields two, and the single output port drains them one per unstalled cycle.
// Reset is asynchronous and active low: mask 0, project-all mode on, parser idle.
// Result stalls let the four-entry queue fill; bytes stall while three or more are held.
module tuple_field_decoder_projected #(
    parameter int MAX_COLUMNS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  tfd_pkg::byte_item_t    byte_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output tfd_pkg::result_item_t  result_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [63:0]            cfg_data
);
    import tfd_pkg::*;

    logic [63:0] column_mask_reg;
    logic        project_all_reg;
    logic        room;
    logic        accept;
    push_t       push;

    // Configuration is a plain register write; it is always taken at once.
    assign cfg_ready  = 1'b1;
    assign byte_stall = !room;
    assign accept     = byte_valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_mask_reg <= '0;
            project_all_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // Writes to indexes beyond the register list are dropped.
            if (cfg_index == CFG_COLUMN_MASK)
            begin
                column_mask_reg <= cfg_data;
            end
            else if (cfg_index == CFG_PROJECT_ALL)
            begin
                project_all_reg <= cfg_data[0];
            end
        end
    end

    // The parser decodes each accepted byte against its state registers in the
    // same cycle and hands its results to the queue, which registers them.
    tfd_decoder #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (byte_item),
        .column_mask (column_mask_reg),
        .project_all (project_all_reg),
        .push        (push)
    );

    tfd_out_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

// ===== hdl/tfd_decoder.sv =====
// Record parser: state registers and the per-byte decode logic.
`timescale 1ns / 1ps

module tfd_decoder #(
    parameter int MAX_COLUMNS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  tfd_pkg::byte_item_t  item,
    input  logic [63:0]          column_mask,
    input  logic                 project_all,
    output tfd_pkg::push_t       push
);
    import tfd_pkg::*;

    localparam logic [63:0] MASK_LIMIT = 64'((65'd1 << MAX_COLUMNS) - 65'd1);

    phase_t      phase_reg, phase_next;
    logic [15:0] field_total_reg, field_total_next;
    logic [15:0] field_index_reg, field_index_next;
    logic [2:0]  current_type_reg, current_type_next;
    logic [3:0]  byte_counter_reg, byte_counter_next;
    logic [63:0] assembly_reg, assembly_next;
    logic [31:0] payload_left_reg, payload_left_next;
    logic        take_field_reg, take_field_next;
    logic [2:0]  error_code_reg, error_code_next;

    logic [63:0]  mask_eff;
    logic [63:0]  byte_wide;
    logic [63:0]  asm_scalar;
    logic [63:0]  asm_length;
    logic [3:0]   bc_inc;
    logic [15:0]  fi_inc;
    logic [15:0]  total_new;
    logic         take_new;
    logic         field_valid;
    result_item_t field_item;
    result_item_t done_item;
    logic [2:0]   done_err;

    assign mask_eff   = column_mask & MASK_LIMIT;
    assign byte_wide  = {56'd0, item.in_byte};
    assign asm_scalar = assembly_reg | (byte_wide << {byte_counter_reg[2:0], 3'b000});
    assign asm_length = assembly_reg | (byte_wide << {1'b0, byte_counter_reg[1:0], 3'b000});
    assign bc_inc     = byte_counter_reg + 4'd1;
    assign fi_inc     = field_index_reg + 16'd1;
    assign total_new  = {item.in_byte, assembly_reg[7:0]};
    assign take_new   = project_all ? 1'b1
                      : ((field_index_reg < 16'd64) ? mask_eff[field_index_reg[5:0]] : 1'b0);

    always_comb
    begin
        phase_next        = phase_reg;
        field_total_next  = field_total_reg;
        field_index_next  = field_index_reg;
        current_type_next = current_type_reg;
        byte_counter_next = byte_counter_reg;
        assembly_next     = assembly_reg;
        payload_left_next = payload_left_reg;
        take_field_next   = take_field_reg;
        error_code_next   = error_code_reg;
        field_valid       = 1'b0;
        field_item        = '0;
        field_item.column = field_index_reg;

        unique case (phase_reg)
            PH_COUNT_LO:
            begin
                assembly_next = byte_wide;
                phase_next    = PH_COUNT_HI;
            end
            PH_COUNT_HI:
            begin
                field_total_next = total_new;
                assembly_next    = '0;
                field_index_next = '0;
                if (!project_all && total_new < 16'd64
                    && (mask_eff >> total_new[5:0]) != 64'd0)
                begin
                    error_code_next = ERR_BAD_PROJ;
                    phase_next      = PH_DROP;
                end
                else
                begin
                    phase_next = (total_new == 16'd0) ? PH_TRAIL : PH_TAG;
                end
            end
            PH_TAG:
            begin
                if (item.in_byte > {5'd0, TYPE_BLOB})
                begin
                    error_code_next = ERR_BAD_TAG;
                    phase_next      = PH_DROP;
                end
                else
                begin
                    current_type_next = item.in_byte[2:0];
                    take_field_next   = take_new;
                    assembly_next     = '0;
                    byte_counter_next = '0;
                    if (item.in_byte[2:0] == TYPE_NULL)
                    begin
                        field_valid          = take_new;
                        field_item.kind      = KIND_SCALAR;
                        field_item.type_code = TYPE_NULL;
                        field_index_next     = fi_inc;
                        phase_next = (fi_inc == field_total_reg) ? PH_TRAIL : PH_TAG;
                    end
                    else if (item.in_byte[2:0] == TYPE_TEXT
                             || item.in_byte[2:0] == TYPE_BLOB)
                    begin
                        phase_next = PH_LENGTH;
                    end
                    else
                    begin
                        phase_next = PH_SCALAR;
                    end
                end
            end
            PH_SCALAR:
            begin
                assembly_next     = asm_scalar;
                byte_counter_next = bc_inc;
                if ((current_type_reg == TYPE_BOOLEAN) || (bc_inc >= 4'd8))
                begin
                    field_valid          = take_field_reg;
                    field_item.kind      = KIND_SCALAR;
                    field_item.type_code = current_type_reg;
                    field_item.data      = (current_type_reg == TYPE_BOOLEAN)
                                         ? {63'd0, (asm_scalar != 64'd0)} : asm_scalar;
                    field_index_next     = fi_inc;
                    phase_next = (fi_inc == field_total_reg) ? PH_TRAIL : PH_TAG;
                end
            end
            PH_LENGTH:
            begin
                assembly_next     = asm_length;
                byte_counter_next = bc_inc;
                if (bc_inc >= 4'd4)
                begin
                    payload_left_next    = asm_length[31:0];
                    field_valid          = take_field_reg;
                    field_item.kind      = KIND_START;
                    field_item.type_code = current_type_reg;
                    field_item.data      = {32'd0, asm_length[31:0]};
                    if (asm_length[31:0] == 32'd0)
                    begin
                        field_index_next = fi_inc;
                        phase_next = (fi_inc == field_total_reg) ? PH_TRAIL : PH_TAG;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                field_valid          = take_field_reg;
                field_item.kind      = KIND_BYTE;
                field_item.type_code = current_type_reg;
                field_item.data      = byte_wide;
                payload_left_next    = payload_left_reg - 32'd1;
                if (payload_left_reg == 32'd1)
                begin
                    field_index_next = fi_inc;
                    phase_next = (fi_inc == field_total_reg) ? PH_TRAIL : PH_TAG;
                end
            end
            PH_TRAIL, PH_DROP:
            begin
            end
            default:
            begin
            end
        endcase

        // The done code follows the phase after this byte is decoded.
        unique case (phase_next)
            PH_DROP:  done_err = error_code_next;
            PH_TAG:   done_err = ERR_NO_TAG;
            PH_TRAIL: done_err = ERR_OK;
            default:  done_err = ERR_TRUNCATED;
        endcase
        done_item       = '0;
        done_item.kind  = KIND_DONE;
        done_item.error = done_err;
        done_item.last  = 1'b1;

        push.first  = field_valid ? field_item : done_item;
        push.second = done_item;
        push.count  = accept ? ({1'b0, field_valid} + {1'b0, item.record_end}) : 2'd0;

        if (item.record_end)
        begin
            phase_next        = PH_COUNT_LO;
            field_total_next  = '0;
            field_index_next  = '0;
            current_type_next = '0;
            byte_counter_next = '0;
            assembly_next     = '0;
            payload_left_next = '0;
            take_field_next   = 1'b0;
            error_code_next   = ERR_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_COUNT_LO;
            field_total_reg  <= '0;
            field_index_reg  <= '0;
            current_type_reg <= '0;
            byte_counter_reg <= '0;
            assembly_reg     <= '0;
            payload_left_reg <= '0;
            take_field_reg   <= 1'b0;
            error_code_reg   <= ERR_OK;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            field_total_reg  <= field_total_next;
            field_index_reg  <= field_index_next;
            current_type_reg <= current_type_next;
            byte_counter_reg <= byte_counter_next;
            assembly_reg     <= assembly_next;
            payload_left_reg <= payload_left_next;
            take_field_reg   <= take_field_next;
            error_code_reg   <= error_code_next;
        end
    end

endmodule

// ===== hdl/tfd_out_queue.sv =====
// Result queue that takes up to two items per cycle and hands out one when not stalled.
`timescale 1ns / 1ps
`include "tuple_field_decoder_projected_assert.svh"

module tfd_out_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tfd_pkg::push_t         push,
    output logic                   room,
    output logic                   result_valid,
    input  logic                   result_stall,
    output tfd_pkg::result_item_t  result_item
);
    import tfd_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    result_item_t entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;
    logic [PW-1:0] wr_ptr_plus1;

    assign pop          = result_valid && !result_stall;
    assign wr_ptr_plus1 = wr_ptr_reg + PW'(1);
    assign result_valid = (count_reg != '0);
    assign result_item  = entry_reg[rd_ptr_reg];
    // A new byte is taken only when two free entries are certain.
    assign room         = (count_reg <= CW'(QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `TFD_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(QUEUE_DEPTH))
    `TFD_ASSERT_NOW(a_push_has_room, clk, rst_n, push.count != 2'd0, room)
    `TFD_ASSERT_NEXT(a_stall_holds, clk, rst_n,
        result_valid && result_stall && push.count == 2'd0,
        $stable(count_reg) && $stable(rd_ptr_reg))

endmodule

// ===== dv/tuple_field_decoder_projected_tb.sv =====
// Self-checking testbench for the row record field decoder with column projection.
`timescale 1ns / 1ps

// The testbench builds encoded row records byte by byte and feeds them to the
// block through a pending queue. Each byte is sent to a local decoder model
// at the clock edge where the block accepts it. The model appends the result
// transactions that the byte should cause to a queue of expected results.
// A monitor compares every accepted result transaction, field by field,
// against the oldest entry of that queue.
//
// The run starts with short directed records. These cover the field extremes,
// every type tag, the error codes and the projection corner cases. Randomized
// phases follow, each under its own register setting. Most random records are
// well formed with random content. The rest are cut short, carry an unknown
// tag, carry trailing bytes, or are plain noise. Registers are written only
// while the block is idle.
module tuple_field_decoder_projected_tb;
    import tfd_pkg::*;

    localparam int MAX_COLS = 64;

    // The block holds at most a four-entry result queue, so the settle wait
    // after the last expected result is well past any work still in flight.
    localparam int SETTLE_CYCLES = 12;

    // A correct run keeps transactions flowing, even under the heaviest
    // random stalls. The limit is far above any gap between transactions
    // in such a run.
    localparam int QUIET_LIMIT = 5000;

    localparam logic [63:0] COL_LIMIT =
        (MAX_COLS >= 64) ? '1 : ((64'd1 << MAX_COLS) - 64'd1);

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         byte_valid = 1'b0;
    logic         byte_stall;
    byte_item_t   byte_item = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_item_t result_item;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = CFG_COLUMN_MASK;
    logic [63:0]  cfg_data = '0;

    tuple_field_decoder_projected #(
        .MAX_COLUMNS(MAX_COLS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .byte_item(byte_item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_item(result_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stimulus bookkeeping. The initial block only appends bytes and counts
    // them as queued. The driver counts the bytes that the block accepts.
    byte_item_t   pending_bytes[$];
    logic [7:0]   rec_bytes[$];
    int           bytes_queued = 0;
    int           bytes_accepted = 0;
    int           sender_idle_pct = 0;
    int           receiver_idle_pct = 0;
    int           failures = 0;
    int           quiet_cycles = 0;
    result_item_t expected_results[$];

    // Local copy of the registers, updated at each configuration handshake.
    logic [63:0]  mask_copy = '0;
    logic         all_copy = 1'b1;

    // Decoder model state. The initial values match the block after reset.
    phase_t       dec_phase = PH_COUNT_LO;
    logic [15:0]  dec_total = '0;
    logic [15:0]  dec_index = '0;
    logic [2:0]   dec_type = TYPE_NULL;
    logic [3:0]   dec_count = '0;
    logic [63:0]  dec_assembly = '0;
    logic [31:0]  dec_left = '0;
    logic         dec_take = 1'b0;
    logic [2:0]   dec_error = ERR_OK;

    task automatic expect_result(input logic [1:0] kind, input logic [15:0] column,
                                 input logic [2:0] type_code, input logic [63:0] data,
                                 input logic [2:0] error, input logic last);
        result_item_t item;
        item.kind = kind;
        item.column = column;
        item.type_code = type_code;
        item.data = data;
        item.error = error;
        item.last = last;
        expected_results.insert(expected_results.size(), item);
    endtask

    // A field is complete. After the last field, any further bytes of the
    // record are trailing bytes and are ignored.
    task automatic advance_field();
        dec_index = dec_index + 16'd1;
        dec_phase = (dec_index == dec_total) ? PH_TRAIL : PH_TAG;
    endtask

    // Decode one accepted byte and queue the results that it causes.
    task automatic decode_byte(input byte_item_t it);
        logic [7:0]  b;
        logic [63:0] limited;
        logic [63:0] value;
        logic [2:0]  err;
        int          need;
        b = it.in_byte;
        limited = mask_copy & COL_LIMIT;
        case (dec_phase)
            PH_COUNT_LO:
            begin
                dec_assembly = {56'd0, b};
                dec_phase = PH_COUNT_HI;
            end
            PH_COUNT_HI:
            begin
                dec_total = {b, dec_assembly[7:0]};
                dec_assembly = '0;
                dec_index = '0;
                // In projected mode, a selected column at or beyond the field
                // count rejects the whole record.
                if (!all_copy && dec_total < 16'd64 && (limited >> dec_total) != 64'd0)
                begin
                    dec_error = ERR_BAD_PROJ;
                    dec_phase = PH_DROP;
                end
                else
                begin
                    dec_phase = (dec_total == 16'd0) ? PH_TRAIL : PH_TAG;
                end
            end
            PH_TAG:
            begin
                if (b > {5'd0, TYPE_BLOB})
                begin
                    dec_error = ERR_BAD_TAG;
                    dec_phase = PH_DROP;
                end
                else
                begin
                    dec_type = b[2:0];
                    if (all_copy)
                        dec_take = 1'b1;
                    else if (dec_index < MAX_COLS && dec_index < 16'd64)
                        dec_take = limited[dec_index[5:0]];
                    else
                        dec_take = 1'b0;
                    dec_assembly = '0;
                    dec_count = '0;
                    if (dec_type == TYPE_NULL)
                    begin
                        if (dec_take)
                            expect_result(KIND_SCALAR, dec_index, TYPE_NULL, '0, ERR_OK, 1'b0);
                        advance_field();
                    end
                    else if (dec_type == TYPE_TEXT || dec_type == TYPE_BLOB)
                    begin
                        dec_phase = PH_LENGTH;
                    end
                    else
                    begin
                        dec_phase = PH_SCALAR;
                    end
                end
            end
            PH_SCALAR:
            begin
                need = (dec_type == TYPE_BOOLEAN) ? 1 : 8;
                dec_assembly = dec_assembly | ({56'd0, b} << (8 * dec_count[2:0]));
                dec_count = dec_count + 4'd1;
                if (dec_count >= need)
                begin
                    value = dec_assembly;
                    if (dec_type == TYPE_BOOLEAN)
                        value = (dec_assembly != 64'd0) ? 64'd1 : 64'd0;
                    if (dec_take)
                        expect_result(KIND_SCALAR, dec_index, dec_type, value, ERR_OK, 1'b0);
                    advance_field();
                end
            end
            PH_LENGTH:
            begin
                dec_assembly = dec_assembly | ({56'd0, b} << (8 * dec_count[1:0]));
                dec_count = dec_count + 4'd1;
                if (dec_count >= 4)
                begin
                    dec_left = dec_assembly[31:0];
                    if (dec_take)
                        expect_result(KIND_START, dec_index, dec_type, {32'd0, dec_left},
                                      ERR_OK, 1'b0);
                    if (dec_left == 32'd0)
                        advance_field();
                    else
                        dec_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (dec_take)
                    expect_result(KIND_BYTE, dec_index, dec_type, {56'd0, b}, ERR_OK, 1'b0);
                dec_left = dec_left - 32'd1;
                if (dec_left == 32'd0)
                    advance_field();
            end
            default:
            begin
            end
        endcase

        // The last byte of a record always closes it with a done transaction.
        // The error code depends on where the decoder stands at that point.
        if (it.record_end)
        begin
            case (dec_phase)
                PH_DROP:  err = dec_error;
                PH_TAG:   err = ERR_NO_TAG;
                PH_TRAIL: err = ERR_OK;
                default:  err = ERR_TRUNCATED;
            endcase
            expect_result(KIND_DONE, 16'd0, TYPE_NULL, 64'd0, err, 1'b1);
            dec_phase = PH_COUNT_LO;
            dec_total = '0;
            dec_index = '0;
            dec_type = TYPE_NULL;
            dec_count = '0;
            dec_assembly = '0;
            dec_left = '0;
            dec_take = 1'b0;
            dec_error = ERR_OK;
        end
    endtask

    // Byte driver. A stalled transaction is held unchanged. Otherwise the
    // next pending byte goes out, unless the sender chooses to idle this cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                decode_byte(byte_item);
                bytes_accepted = bytes_accepted + 1;
            end
            if (byte_valid && byte_stall)
            begin
                byte_valid <= 1'b1;
            end
            else if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                byte_valid <= 1'b1;
                byte_item <= pending_bytes.pop_front();
            end
            else
            begin
                byte_valid <= 1'b0;
            end
        end
    end

    // Result monitor, which also drives the random stall on the result side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin : check_result
                result_item_t want;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: kind %0h column %0h data %0h",
                           result_item.kind, result_item.column, result_item.data);
                    failures = failures + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_item.kind !== want.kind)
                    begin
                        $error("kind expected %0h actual %0h", want.kind, result_item.kind);
                        failures = failures + 1;
                    end
                    if (result_item.column !== want.column)
                    begin
                        $error("column expected %0h actual %0h", want.column, result_item.column);
                        failures = failures + 1;
                    end
                    if (result_item.type_code !== want.type_code)
                    begin
                        $error("type_code expected %0h actual %0h", want.type_code,
                               result_item.type_code);
                        failures = failures + 1;
                    end
                    if (result_item.data !== want.data)
                    begin
                        $error("data expected %0h actual %0h", want.data, result_item.data);
                        failures = failures + 1;
                    end
                    if (result_item.error !== want.error)
                    begin
                        $error("error expected %0h actual %0h", want.error, result_item.error);
                        failures = failures + 1;
                    end
                    if (result_item.last !== want.last)
                    begin
                        $error("last expected %0h actual %0h", want.last, result_item.last);
                        failures = failures + 1;
                    end
                end
            end
            result_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    // Watchdog: ends the run if no transaction happens on any channel for
    // too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic write_register(input logic [1:0] index, input logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == CFG_COLUMN_MASK)
            mask_copy = value;
        else
            all_copy = value[0];
    endtask

    task automatic set_config(input logic [63:0] mask, input logic all);
        write_register(CFG_COLUMN_MASK, mask);
        write_register(CFG_PROJECT_ALL, {63'd0, all});
    endtask

    // Wait until every queued byte has been accepted and every expected
    // result has arrived. Then let the pipeline settle.
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || bytes_accepted != bytes_queued
               || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Add one byte at the end of the record being built.
    task automatic append_byte(input logic [7:0] b);
        rec_bytes.insert(rec_bytes.size(), b);
    endtask

    task automatic start_record(input logic [15:0] count);
        rec_bytes.delete();
        append_byte(count[7:0]);
        append_byte(count[15:8]);
    endtask

    // Append one field: the tag, then the payload. For text and blob fields,
    // the length and the number of payload bytes written may differ, which
    // builds records that are cut short.
    task automatic add_field(input logic [2:0] ty, input logic [63:0] val,
                             input logic [31:0] len, input int nbytes);
        append_byte({5'd0, ty});
        case (ty)
            TYPE_INTEGER, TYPE_REAL:
                for (int i = 0; i < 8; i++)
                    append_byte(val[8 * i +: 8]);
            TYPE_BOOLEAN:
                append_byte(val[7:0]);
            TYPE_TEXT, TYPE_BLOB:
            begin
                for (int i = 0; i < 4; i++)
                    append_byte(len[8 * i +: 8]);
                repeat (nbytes) append_byte(8'($urandom));
            end
            default:
            begin
            end
        endcase
    endtask

    // Queue the record built so far. A cut between 1 and the record size
    // ends the record early at that byte.
    task automatic send_record(input int cut);
        byte_item_t item;
        int         n;
        n = (cut > 0 && cut < rec_bytes.size()) ? cut : rec_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            item.in_byte = rec_bytes[i];
            item.record_end = (i == n - 1);
            pending_bytes.insert(pending_bytes.size(), item);
        end
        bytes_queued = bytes_queued + n;
    endtask

    // Random fields. A bad_at index below the field count puts an unknown
    // tag there, followed by a few bytes that the block must drop. Long
    // records are mostly null fields, which keeps them short in bytes.
    task automatic build_record(input int nfields, input int bad_at);
        logic [2:0]  ty;
        logic [63:0] val;
        logic [31:0] len;
        start_record(16'(nfields));
        for (int f = 0; f < nfields; f++)
        begin
            if (f == bad_at)
            begin
                append_byte(8'($urandom_range(6, 255)));
                repeat ($urandom_range(0, 3)) append_byte(8'($urandom));
                return;
            end
            ty = 3'($urandom_range(0, 5));
            if (nfields > 8 && $urandom_range(0, 3) != 0)
                ty = TYPE_NULL;
            if ($urandom_range(0, 7) == 0)
                val = {64{$urandom_range(0, 1) == 1}};
            else
                val = {$urandom, $urandom};
            if (ty == TYPE_BOOLEAN && $urandom_range(0, 3) == 0)
                val = '0;
            len = $urandom_range(0, 5);
            add_field(ty, val, len, len);
        end
    endtask

    // Mix of records: mostly well formed, plus trailing bytes, cut records,
    // unknown tags and noise. big_pct sets how often the field count is drawn
    // from 60 to 70, around the 64 columns that the mask can select.
    task automatic random_record(input int big_pct);
        int roll;
        int nfields;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < big_pct)
            nfields = $urandom_range(60, 70);
        else
            nfields = $urandom_range(0, 8);
        if (roll < 10)
        begin
            rec_bytes.delete();
            repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
            send_record(0);
        end
        else
        begin
            if (roll < 18 && nfields > 0)
                build_record(nfields, $urandom_range(0, nfields - 1));
            else
                build_record(nfields, -1);
            if (roll >= 18 && roll < 28)
                repeat ($urandom_range(1, 4)) append_byte(8'($urandom));
            if (roll >= 28 && roll < 42)
                send_record($urandom_range(1, rec_bytes.size()));
            else
                send_record(0);
        end
    endtask

    initial
    begin
        int p;
        int target;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        sender_idle_pct = 26;
        receiver_idle_pct = 74;

        // Directed records with every column selected.
        set_config('1, 1'b1);
        start_record(16'd0);
        send_record(0);
        // The record ends inside the count.
        start_record(16'd5);
        send_record(1);
        // One field of every type, with extreme values.
        start_record(16'd6);
        add_field(TYPE_NULL, '0, 0, 0);
        add_field(TYPE_INTEGER, '1, 0, 0);
        add_field(TYPE_REAL, 64'h7FF0_0000_0000_0001, 0, 0);
        add_field(TYPE_TEXT, '0, 3, 3);
        add_field(TYPE_BOOLEAN, 64'hFF, 0, 0);
        add_field(TYPE_BLOB, '0, 0, 0);
        send_record(0);
        // Zero integer, both boolean values, then trailing bytes.
        start_record(16'd3);
        add_field(TYPE_INTEGER, '0, 0, 0);
        add_field(TYPE_BOOLEAN, '0, 0, 0);
        add_field(TYPE_BOOLEAN, 64'd1, 0, 0);
        append_byte(8'hA5);
        append_byte(8'h5A);
        send_record(0);
        // The record ends where a tag is due.
        start_record(16'd1);
        send_record(0);
        // The lowest unknown tag, followed by a dropped byte.
        start_record(16'd2);
        add_field(TYPE_NULL, '0, 0, 0);
        append_byte(8'd6);
        append_byte(8'h00);
        send_record(0);
        // The highest unknown tag.
        start_record(16'd1);
        append_byte(8'hFF);
        send_record(0);
        // The record ends inside a length, then inside a payload, then
        // inside an integer.
        start_record(16'd1);
        add_field(TYPE_TEXT, '0, 9, 0);
        send_record(5);
        start_record(16'd1);
        add_field(TYPE_BLOB, '0, 4, 4);
        send_record(9);
        start_record(16'd1);
        add_field(TYPE_INTEGER, {$urandom, $urandom}, 0, 0);
        send_record(8);
        // Largest count, and a count with only the high byte set.
        start_record(16'hFFFF);
        send_record(0);
        start_record(16'h0100);
        add_field(TYPE_NULL, '0, 0, 0);
        add_field(TYPE_NULL, '0, 0, 0);
        send_record(0);
        // Largest length; the record ends long before the payload does.
        start_record(16'd1);
        add_field(TYPE_TEXT, '0, 32'hFFFF_FFFF, 3);
        send_record(0);
        wait_idle();

        // Empty projection: only the done transaction comes out.
        set_config('0, 1'b0);
        start_record(16'd3);
        add_field(TYPE_INTEGER, {$urandom, $urandom}, 0, 0);
        add_field(TYPE_TEXT, '0, 2, 2);
        add_field(TYPE_NULL, '0, 0, 0);
        send_record(0);
        wait_idle();

        // Column 2 is selected. It lies beyond a two-field record, which is a
        // bad projection, and inside a three-field record.
        set_config(64'd4, 1'b0);
        start_record(16'd2);
        add_field(TYPE_NULL, '0, 0, 0);
        add_field(TYPE_NULL, '0, 0, 0);
        send_record(0);
        start_record(16'd3);
        add_field(TYPE_INTEGER, {$urandom, $urandom}, 0, 0);
        add_field(TYPE_TEXT, '0, 1, 1);
        add_field(TYPE_BOOLEAN, 64'd1, 0, 0);
        send_record(0);
        wait_idle();

        // Every column is selected: 64 fields pass, 63 fields do not.
        set_config('1, 1'b0);
        start_record(16'd64);
        for (int i = 0; i < 64; i++)
            add_field(3'(i % 6), {$urandom, $urandom}, 1, 1);
        send_record(0);
        start_record(16'd63);
        add_field(TYPE_NULL, '0, 0, 0);
        send_record(0);
        wait_idle();

        // Random phases. Each has its own register setting, and each group of
        // three phases has its own pattern of idle and stall cycles.
        for (p = 0; p < 9; p++)
        begin
            sender_idle_pct = (p < 3) ? 26 : (p < 6) ? 74 : 0;
            receiver_idle_pct = (p < 3) ? 74 : (p < 6) ? 26 : 0;
            case (p)
                0: set_config({$urandom, $urandom}, 1'b1);
                3: set_config('1, 1'b0);
                4: set_config('0, 1'b0);
                6: set_config({$urandom, $urandom}, 1'b0);
                7: set_config(64'h8000_0000_0000_0001, 1'b0);
                8: set_config('0, 1'b1);
                default: set_config(64'($urandom_range(0, 255)), 1'b0);
            endcase
            if (p == 0)
                target = bytes_queued + 140;
            else if (p == 4 || p == 8)
                target = bytes_queued + 80;
            else
                target = bytes_queued + 100;
            while (bytes_queued < target)
                random_record((p == 3 || p == 6 || p == 7) ? 40 : 8);
            wait_idle();
        end

        if (failures == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== tuple_field_decoder_projected.f =====
+incdir+hdl
hdl/tfd_pkg.sv
hdl/tfd_decoder.sv
hdl/tfd_out_queue.sv
hdl/tuple_field_decoder_projected.sv
dv/tuple_field_decoder_projected_tb.sv
